@@ design/safe_pkg.sv @@
// ----------------------------------------------------------------------------
// safe_pkg: shared types and constants of the slot allocator
// Pool sizes, field widths, stream packing, opcodes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package safe_pkg;

    localparam int NUM_SLOTS   = 16;
    localparam int NUM_CLASSES = 10;

    // Field widths fixed by the stream format
    localparam int SLOT_W      = 4;
    localparam int CLS_FIELD_W = 4;
    localparam int HANDLE_W    = 16;

    // Internal widths derived from pool sizes
    localparam int DEPTH  = NUM_CLASSES * NUM_SLOTS;
    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;
    localparam int IN_HANDLE_LSB = CLS_FIELD_W;
    localparam int IN_SLOT_LSB   = CLS_FIELD_W + HANDLE_W;
    localparam int OUT_PAD_W     = OUT_DATA_W - SLOT_W - HANDLE_W;

    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [ADDR_W-1:0]   t_addr;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef struct packed {
        logic latch_in;
        logic pop_commit;
        logic sweep_start;
        logic sweep_step;
        logic own_commit;
        logic rel_commit;
        logic res_reject;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic class_ok;
        logic is_release;
        logic free_empty;
        logic rel_ok;
        logic sweep_done;
        logic out_free;
    } t_stat;

    // Flat address of entry idx in the pool of class cls
    function automatic t_addr mem_addr(input logic [CLS_W-1:0] cls,
                                       input logic [IDX_W-1:0] idx);
        return ADDR_W'(cls) * ADDR_W'(NUM_SLOTS) + ADDR_W'(idx);
    endfunction

endpackage

@@ design/safe_ctrl.sv @@
// ----------------------------------------------------------------------------
// safe_ctrl: sequencer of the slot allocator
// Takes one request at a time, steers the datapath through pop, used-list
// sweep and commit steps, and hands the result to the output register.
// ----------------------------------------------------------------------------
module safe_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  safe_pkg::t_stat  i_stat,
    output safe_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_SWEEP,
        ST_OWN_WR,
        ST_REL_FIN,
        ST_RESULT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ready;

    assign o_s_tready = r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && r_ready) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_stat.class_ok) begin
                    o_cmd.res_reject = 1'b1;
                    n_state          = ST_RESULT;
                end else if (!i_stat.is_release) begin
                    if (i_stat.free_empty) begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = ST_SWEEP;
                    end else begin
                        n_state = ST_POP;
                    end
                end else if (i_stat.rel_ok) begin
                    o_cmd.sweep_start = 1'b1;
                    n_state           = ST_SWEEP;
                end else begin
                    o_cmd.res_reject = 1'b1;
                    n_state          = ST_RESULT;
                end
            end
            ST_POP: begin
                o_cmd.pop_commit = 1'b1;
                n_state          = ST_RESULT;
            end
            ST_SWEEP: begin
                if (i_stat.sweep_done) begin
                    n_state = i_stat.is_release ? ST_REL_FIN : ST_OWN_WR;
                end else begin
                    o_cmd.sweep_step = 1'b1;
                end
            end
            ST_OWN_WR: begin
                o_cmd.own_commit = 1'b1;
                n_state          = ST_RESULT;
            end
            ST_REL_FIN: begin
                o_cmd.rel_commit = 1'b1;
                n_state          = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == ST_IDLE);
        end
    end

endmodule

@@ design/safe_datapath.sv @@
// ----------------------------------------------------------------------------
// safe_datapath: pool storage and result path of the slot allocator
// Holds the free stacks, used lists and owner tables of all classes, the
// per-class counters, the in-use bits, the request latch and the output
// register.
// ----------------------------------------------------------------------------
module safe_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  safe_pkg::t_cmd                      i_cmd,
    output safe_pkg::t_stat                     o_stat,
    // fields from bit 0 up: class_sel, handle, slot_in
    input  logic [safe_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // op
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // fields from bit 0 up: slot_out, evicted_handle, zero pad
    output logic [safe_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // fields from bit 0 up: evicted_valid, status
    output logic [safe_pkg::OUT_USER_W-1:0]     o_m_tuser
);

    // Request latch
    safe_pkg::t_op                        r_op;
    logic [safe_pkg::CLS_FIELD_W-1:0]     r_cls;
    safe_pkg::t_handle                    r_handle;
    safe_pkg::t_slot                      r_slot;

    // Per-class counters and in-use bits
    safe_pkg::t_cnt                       r_fc  [safe_pkg::NUM_CLASSES];
    safe_pkg::t_cnt                       r_low [safe_pkg::NUM_CLASSES];
    logic [safe_pkg::DEPTH-1:0]           r_in_use;

    // Pool memories
    safe_pkg::t_slot                      fs_mem  [safe_pkg::DEPTH];
    safe_pkg::t_slot                      uo_mem  [safe_pkg::DEPTH];
    safe_pkg::t_handle                    own_mem [safe_pkg::DEPTH];
    safe_pkg::t_slot                      r_fs_rdata;
    safe_pkg::t_slot                      r_uo_rdata;
    safe_pkg::t_handle                    r_own_rdata;

    // Sweep state
    safe_pkg::t_cnt                       r_k;
    safe_pkg::t_cnt                       r_j;
    logic                                 r_pend;
    logic                                 r_found;

    // Result and output register
    safe_pkg::t_slot                      r_res_slot;
    logic                                 r_res_ev;
    safe_pkg::t_handle                    r_res_handle;
    logic                                 r_res_status;
    logic                                 r_out_valid;
    safe_pkg::t_slot                      r_out_slot;
    logic                                 r_out_ev;
    safe_pkg::t_handle                    r_out_handle;
    logic                                 r_out_status;

    logic                                 class_ok;
    logic [safe_pkg::CLS_W-1:0]           cls_idx;
    safe_pkg::t_cnt                       cur_fc;
    safe_pkg::t_cnt                       cur_low;
    safe_pkg::t_cnt                       n_used;
    safe_pkg::t_cnt                       top_idx;
    logic                                 top_fresh;
    safe_pkg::t_slot                      pop_slot;
    logic                                 slot_ok;
    safe_pkg::t_addr                      a_slot;
    safe_pkg::t_addr                      a_pop;
    logic                                 is_evict;
    logic                                 sweep_we;

    safe_pkg::t_addr                      fs_raddr;
    safe_pkg::t_addr                      fs_waddr;
    safe_pkg::t_addr                      uo_raddr;
    safe_pkg::t_addr                      uo_waddr;
    safe_pkg::t_slot                      uo_wdata;
    logic                                 uo_we;
    safe_pkg::t_addr                      own_waddr;
    logic                                 own_we;

    assign class_ok = 32'(r_cls) < 32'(safe_pkg::NUM_CLASSES);
    assign cls_idx  = class_ok ? safe_pkg::CLS_W'(r_cls) : '0;
    assign cur_fc   = r_fc[cls_idx];
    assign cur_low  = r_low[cls_idx];
    assign n_used   = safe_pkg::CNT_W'(safe_pkg::NUM_SLOTS) - cur_fc;
    assign top_idx  = cur_fc - safe_pkg::CNT_W'(1);
    // Stack entries below the low-water mark were never overwritten
    assign top_fresh = top_idx < cur_low;
    assign pop_slot  = top_fresh ? safe_pkg::SLOT_W'(top_idx) : r_fs_rdata;
    assign slot_ok   = 32'(r_slot) < 32'(safe_pkg::NUM_SLOTS);
    assign a_slot    = safe_pkg::mem_addr(cls_idx, safe_pkg::IDX_W'(r_slot));
    assign a_pop     = safe_pkg::mem_addr(cls_idx, safe_pkg::IDX_W'(pop_slot));
    assign is_evict  = (r_op == safe_pkg::OP_ACQUIRE);
    assign sweep_we  = i_cmd.sweep_step && r_pend && r_found;

    assign fs_raddr = safe_pkg::mem_addr(cls_idx, safe_pkg::IDX_W'(top_idx));
    assign fs_waddr = safe_pkg::mem_addr(cls_idx, safe_pkg::IDX_W'(cur_fc));
    assign uo_raddr = safe_pkg::mem_addr(cls_idx, safe_pkg::IDX_W'(r_k));

    always_comb begin
        uo_we    = 1'b0;
        uo_waddr = safe_pkg::mem_addr(cls_idx, safe_pkg::IDX_W'(n_used));
        uo_wdata = pop_slot;
        if (i_cmd.pop_commit) begin
            uo_we = 1'b1;
        end else if (sweep_we) begin
            // shift entry j down to j-1
            uo_we    = 1'b1;
            uo_waddr = safe_pkg::mem_addr(cls_idx,
                                          safe_pkg::IDX_W'(r_j - safe_pkg::CNT_W'(1)));
            uo_wdata = r_uo_rdata;
        end else if (i_cmd.own_commit) begin
            // evicted slot goes to the back of the list
            uo_we    = 1'b1;
            uo_waddr = safe_pkg::mem_addr(cls_idx,
                                          safe_pkg::IDX_W'(n_used - safe_pkg::CNT_W'(1)));
            uo_wdata = r_slot;
        end
    end

    assign own_we    = i_cmd.pop_commit || i_cmd.own_commit;
    assign own_waddr = i_cmd.pop_commit ? a_pop : a_slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rel_commit) begin
            fs_mem[fs_waddr] <= r_slot;
        end
        r_fs_rdata <= fs_mem[fs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (uo_we) begin
            uo_mem[uo_waddr] <= uo_wdata;
        end
        r_uo_rdata <= uo_mem[uo_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            own_mem[own_waddr] <= r_handle;
        end
        r_own_rdata <= own_mem[a_slot];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < safe_pkg::NUM_CLASSES; c++) begin
                r_fc[c]  <= safe_pkg::CNT_W'(safe_pkg::NUM_SLOTS);
                r_low[c] <= safe_pkg::CNT_W'(safe_pkg::NUM_SLOTS);
            end
            r_in_use    <= '0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop_commit) begin
                r_fc[cls_idx]   <= top_idx;
                r_in_use[a_pop] <= 1'b1;
                if (top_fresh) begin
                    r_low[cls_idx] <= top_idx;
                end
            end
            if (i_cmd.rel_commit) begin
                r_fc[cls_idx]    <= cur_fc + safe_pkg::CNT_W'(1);
                r_in_use[a_slot] <= 1'b0;
            end
            if (i_cmd.sweep_start) begin
                r_k     <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.sweep_step) begin
                if (r_k < n_used) begin
                    r_k    <= r_k + safe_pkg::CNT_W'(1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
                // eviction takes the head entry; release looks for its slot
                if (r_pend && !r_found && (is_evict || r_uo_rdata == r_slot)) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op     <= safe_pkg::t_op'(i_s_tuser);
            r_cls    <= i_s_tdata[safe_pkg::CLS_FIELD_W-1:0];
            r_handle <= i_s_tdata[safe_pkg::IN_HANDLE_LSB +: safe_pkg::HANDLE_W];
            r_slot   <= i_s_tdata[safe_pkg::IN_SLOT_LSB +: safe_pkg::SLOT_W];
        end else if (i_cmd.sweep_step && r_pend && !r_found && is_evict) begin
            r_slot <= r_uo_rdata;
        end
        if (i_cmd.sweep_step && r_k < n_used) begin
            r_j <= r_k;
        end

        if (i_cmd.res_reject) begin
            r_res_slot   <= (r_op == safe_pkg::OP_RELEASE) ? r_slot : '0;
            r_res_ev     <= 1'b0;
            r_res_handle <= '0;
            r_res_status <= safe_pkg::STATUS_IGNORED;
        end else if (i_cmd.pop_commit) begin
            r_res_slot   <= pop_slot;
            r_res_ev     <= 1'b0;
            r_res_handle <= '0;
            r_res_status <= safe_pkg::STATUS_OK;
        end else if (i_cmd.own_commit) begin
            r_res_slot   <= r_slot;
            r_res_ev     <= 1'b1;
            r_res_handle <= r_own_rdata;
            r_res_status <= safe_pkg::STATUS_OK;
        end else if (i_cmd.rel_commit) begin
            r_res_slot   <= r_slot;
            r_res_ev     <= 1'b0;
            r_res_handle <= '0;
            r_res_status <= safe_pkg::STATUS_OK;
        end

        if (i_cmd.load_out) begin
            r_out_slot   <= r_res_slot;
            r_out_ev     <= r_res_ev;
            r_out_handle <= r_res_handle;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.class_ok   = class_ok;
    assign o_stat.is_release = (r_op == safe_pkg::OP_RELEASE);
    assign o_stat.free_empty = (cur_fc == '0);
    assign o_stat.rel_ok     = slot_ok && r_in_use[a_slot];
    assign o_stat.sweep_done = !r_pend && (r_k == n_used);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{safe_pkg::OUT_PAD_W{1'b0}}, r_out_handle, r_out_slot};
    assign o_m_tuser  = {r_out_status, r_out_ev};

endmodule

@@ design/slot_allocator_fifo_evict.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_fifo_evict: per-class binding slot allocator
// Each class owns a pool of slots with a free stack, an allocation-ordered
// used list and an owner table; acquire evicts the oldest slot when none is
// free.
//
// Usage: requests arrive on s_axis (tuser = op, tdata = class_sel, handle,
// slot_in); every request yields exactly one result on m_axis (tdata =
// slot_out, evicted_handle; tuser = evicted_valid, status). One request is
// in work at a time; s_axis_tready is high only while the block waits.
// A request with a bad class, or a release of a slot not in use, is rejected;
// an acquire with free slots pops the free stack; release and eviction sweep
// the class's used list, one entry per cycle through the single read port of
// the used-list memory.
// The result sits in an output register, so a new request is accepted while
// the previous result waits; a stalled receiver holds the sequencer only when
// the next result is ready. Reset restores every pool at once, with no
// clearing pass: all slots free, stacks handing out slot NUM_SLOTS-1 first.
// ----------------------------------------------------------------------------
module slot_allocator_fifo_evict (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0 up: class_sel[3:0], handle[19:4], slot_in[23:20]
    input  logic [safe_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields from bit 0 up: slot_out[3:0], evicted_handle[19:4], zero pad
    output logic [safe_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // fields from bit 0 up: evicted_valid, status
    output logic [safe_pkg::OUT_USER_W-1:0]     m_axis_tuser
);

    safe_pkg::t_cmd  w_cmd;
    safe_pkg::t_stat w_stat;

    safe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    safe_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser)
    );

    // One request in work: the port closes right after a transfer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a request is in work");

    // A pop only happens on a valid class with free slots left
    a_pop_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop_commit |-> w_stat.class_ok && !w_stat.free_empty)
        else $error("free stack popped when empty or for a bad class");

    // An eviction is never reported on an ignored request
    a_evict_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("eviction flagged on an ignored request");

    // Without an eviction the evicted handle reads zero
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[safe_pkg::SLOT_W +: safe_pkg::HANDLE_W] == '0)
        else $error("evicted handle nonzero without eviction");

endmodule

@@ tb/slot_allocator_fifo_evict_test.sv @@
// ----------------------------------------------------------------------------
// slot_allocator_fifo_evict_test: self-checking bench for the slot allocator
// Streams acquire and release requests into the block, predicts every grant
// from a shadow copy of the per-class pools and compares each result transfer
// against it. Runs directed corner cases, then random traffic focused on a
// few classes so pools fill up and evict, under several idle/stall patterns.
// ----------------------------------------------------------------------------
module slot_allocator_fifo_evict_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 50;
    localparam int REPORT_MAX  = 10;

    localparam int MODE_NONE    = 0;
    localparam int MODE_SRC_GAP = 1;
    localparam int MODE_SNK_GAP = 2;
    localparam int MODE_BOTH    = 3;

    typedef struct packed {
        safe_pkg::t_op     op;
        logic [3:0]        cls;
        safe_pkg::t_handle handle;
        safe_pkg::t_slot   slot;
    } t_alloc_req;

    typedef struct packed {
        safe_pkg::t_slot   slot;
        logic              evicted;
        safe_pkg::t_handle ev_handle;
        logic              status;
    } t_alloc_grant;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // fields from bit 0 up: class_sel[3:0], handle[19:4], slot_in[23:20]
    logic [safe_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    // op
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // fields from bit 0 up: slot_out[3:0], evicted_handle[19:4], zero pad
    logic [safe_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    // fields from bit 0 up: evicted_valid, status
    logic [safe_pkg::OUT_USER_W-1:0] m_axis_tuser;

    slot_allocator_fifo_evict dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow pools
    safe_pkg::t_slot   free_stk [safe_pkg::NUM_CLASSES][safe_pkg::NUM_SLOTS];
    int                free_cnt [safe_pkg::NUM_CLASSES];
    safe_pkg::t_slot   used_lst [safe_pkg::NUM_CLASSES][safe_pkg::NUM_SLOTS];
    int                used_cnt [safe_pkg::NUM_CLASSES];
    safe_pkg::t_handle owner    [safe_pkg::NUM_CLASSES][safe_pkg::NUM_SLOTS];
    bit                busy     [safe_pkg::NUM_CLASSES][safe_pkg::NUM_SLOTS];

    t_alloc_req   req_queue[$];
    t_alloc_grant pending_grants[$];
    t_alloc_req   cur_req;

    int idle_mode = MODE_NONE;
    int cycles = 0;
    int mismatches = 0;
    int n_evict = 0;
    int n_ignored = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_alloc_grant predict_grant(t_alloc_req r);
        t_alloc_grant    g;
        int              c;
        int              pos;
        safe_pkg::t_slot s;
        g.slot      = '0;
        g.evicted   = 1'b0;
        g.ev_handle = '0;
        g.status    = safe_pkg::STATUS_OK;
        c = int'(r.cls);
        if (c >= safe_pkg::NUM_CLASSES) begin
            g.slot   = (r.op == safe_pkg::OP_RELEASE) ? r.slot : '0;
            g.status = safe_pkg::STATUS_IGNORED;
            return g;
        end
        if (r.op == safe_pkg::OP_ACQUIRE) begin
            if (free_cnt[c] > 0) begin
                free_cnt[c]--;
                s = free_stk[c][free_cnt[c]];
                used_lst[c][used_cnt[c]] = s;
                used_cnt[c]++;
                owner[c][s] = r.handle;
                busy[c][s]  = 1'b1;
                g.slot = s;
            end else if (used_cnt[c] == 0) begin
                g.status = safe_pkg::STATUS_IGNORED;
            end else begin
                // rotate the oldest entry to the back and take it over
                s = used_lst[c][0];
                for (int k = 0; k + 1 < used_cnt[c]; k++)
                    used_lst[c][k] = used_lst[c][k+1];
                used_lst[c][used_cnt[c]-1] = s;
                g.slot      = s;
                g.evicted   = 1'b1;
                g.ev_handle = owner[c][s];
                owner[c][s] = r.handle;
                busy[c][s]  = 1'b1;
            end
        end else begin
            g.slot = r.slot;
            if (!busy[c][r.slot]) begin
                g.status = safe_pkg::STATUS_IGNORED;
            end else begin
                pos = used_cnt[c];
                for (int k = 0; k < used_cnt[c]; k++) begin
                    if (used_lst[c][k] == r.slot && pos == used_cnt[c])
                        pos = k;
                end
                for (int k = pos; k + 1 < used_cnt[c]; k++)
                    used_lst[c][k] = used_lst[c][k+1];
                if (pos < used_cnt[c])
                    used_cnt[c]--;
                free_stk[c][free_cnt[c]] = r.slot;
                free_cnt[c]++;
                busy[c][r.slot] = 1'b0;
            end
        end
        return g;
    endfunction

    task automatic push_req(safe_pkg::t_op op, int cls, int handle, int slot);
        t_alloc_req r;
        r.op     = op;
        r.cls    = 4'(cls);
        r.handle = 16'(handle);
        r.slot   = 4'(slot);
        req_queue.push_back(r);
    endtask

    task automatic add_random(int n);
        int roll;
        int cls;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                // noise: any class, any op, including out-of-range classes
                push_req(safe_pkg::t_op'($urandom_range(1)), $urandom_range(15),
                         $urandom_range(16'hFFFF), $urandom_range(15));
            end else begin
                // concentrate on a few pools so they run full and evict
                cls = ($urandom_range(99) < 80) ? $urandom_range(2)
                                                : $urandom_range(safe_pkg::NUM_CLASSES - 1);
                push_req(($urandom_range(99) < 62) ? safe_pkg::OP_ACQUIRE
                                                   : safe_pkg::OP_RELEASE, cls,
                         $urandom_range(16'hFFFF), $urandom_range(safe_pkg::NUM_SLOTS - 1));
            end
        end
    endtask

    task automatic drain_all();
        while (req_queue.size() != 0 || s_axis_tvalid || pending_grants.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: present requests, predict at each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                pending_grants.push_back(predict_grant(cur_req));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (req_queue.size() != 0 &&
                    !((idle_mode == MODE_SRC_GAP || idle_mode == MODE_BOTH) &&
                      $urandom_range(99) < ((idle_mode == MODE_BOTH) ? 23 : 61))) begin
                    cur_req = req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_req.slot, cur_req.handle, cur_req.cls};
                    s_axis_tuser  <= cur_req.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side and check each result transfer
    always @(posedge i_clk) begin
        t_alloc_grant exp_g;
        t_alloc_grant got_g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_g.slot      = m_axis_tdata[safe_pkg::SLOT_W-1:0];
                got_g.ev_handle = m_axis_tdata[safe_pkg::SLOT_W +: safe_pkg::HANDLE_W];
                got_g.evicted   = m_axis_tuser[0];
                got_g.status    = m_axis_tuser[1];
                if (pending_grants.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("ERROR: unexpected result slot=%0d ev=%0b h=%h st=%0b",
                                 got_g.slot, got_g.evicted, got_g.ev_handle,
                                 got_g.status);
                end else begin
                    exp_g = pending_grants.pop_front();
                    if (got_g != exp_g) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"ERROR: grant mismatch exp slot=%0d ev=%0b h=%h ",
                                      "st=%0b, got slot=%0d ev=%0b h=%h st=%0b"},
                                     exp_g.slot, exp_g.evicted, exp_g.ev_handle,
                                     exp_g.status, got_g.slot, got_g.evicted,
                                     got_g.ev_handle, got_g.status);
                    end
                    if (exp_g.status == safe_pkg::STATUS_IGNORED)
                        n_ignored++;
                    else if (exp_g.evicted)
                        n_evict++;
                end
            end
            m_axis_tready <= !((idle_mode == MODE_SNK_GAP || idle_mode == MODE_BOTH) &&
                               $urandom_range(99) < ((idle_mode == MODE_BOTH) ? 23 : 61));
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < safe_pkg::NUM_CLASSES; c++) begin
            for (int i = 0; i < safe_pkg::NUM_SLOTS; i++) begin
                free_stk[c][i] = safe_pkg::t_slot'(i);
                busy[c][i]     = 1'b0;
            end
            free_cnt[c] = safe_pkg::NUM_SLOTS;
            used_cnt[c] = 0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners
        push_req(safe_pkg::OP_ACQUIRE, 0, 16'h0000, 0);
        push_req(safe_pkg::OP_ACQUIRE, 0, 16'hFFFF, 15);
        push_req(safe_pkg::OP_RELEASE, 0, 16'hFFFF, safe_pkg::NUM_SLOTS - 1);
        push_req(safe_pkg::OP_RELEASE, 0, 16'h0000, safe_pkg::NUM_SLOTS - 1);  // already free
        push_req(safe_pkg::OP_RELEASE, 0, 16'h1234, 0);               // never acquired
        push_req(safe_pkg::OP_ACQUIRE, 15, 16'hFFFF, 15);              // bad class
        push_req(safe_pkg::OP_RELEASE, safe_pkg::NUM_CLASSES, 16'h0000, 7);  // bad class
        for (int i = 0; i < safe_pkg::NUM_SLOTS; i++)
            push_req(safe_pkg::OP_ACQUIRE, safe_pkg::NUM_CLASSES - 1, 16'hA000 + i, 0);
        // evict oldest, remove mid-list, refill from free
        push_req(safe_pkg::OP_ACQUIRE, safe_pkg::NUM_CLASSES - 1, 16'hBEEF, 0);
        push_req(safe_pkg::OP_RELEASE, safe_pkg::NUM_CLASSES - 1, 16'h0000, 8);
        push_req(safe_pkg::OP_ACQUIRE, safe_pkg::NUM_CLASSES - 1, 16'hC0DE, 0);
        drain_all();

        idle_mode = MODE_NONE;
        add_random(130);
        drain_all();
        idle_mode = MODE_SRC_GAP;
        add_random(130);
        drain_all();
        idle_mode = MODE_SNK_GAP;
        add_random(130);
        drain_all();
        idle_mode = MODE_BOTH;
        add_random(130);
        drain_all();

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (pending_grants.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", pending_grants.size());
        end

        $display("Covered %0d cycles: %0d evictions, %0d ignored requests,", cycles,
                 n_evict, n_ignored);
        $display("four idle/stall patterns, %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ slot_allocator_fifo_evict.f @@
design/safe_pkg.sv
design/safe_ctrl.sv
design/safe_datapath.sv
design/slot_allocator_fifo_evict.sv
tb/slot_allocator_fifo_evict_test.sv
